// ===== rtl/vwcp_pkg.sv =====
// Package for the variable width code packer.
// Holds the shared constants and the job record passed from front to back.
// No dependencies.
package vwcp_pkg;

  localparam int ByteW           = 8;
  localparam int CountW          = 3;
  localparam int CodeWidthW      = 5;
  localparam int MinCodeWidth    = 9;
  localparam int DefMaxCodeWidth = 16;
  localparam int DefQueueDepth   = 4;

  localparam logic FuncAppend = 1'b0;
  localparam logic FuncFlush  = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic             two;
  } job_t;

endpackage

// ===== rtl/vwcp_front.sv =====
// Front part of the code packer: accepts requests, merges codes with pending bits.
// Jobs: 1-2 bytes per append, 1 per flush with bits pending; depends on vwcp_pkg.
module vwcp_front #(
  parameter int MaxCodeWidth = vwcp_pkg::DefMaxCodeWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                func_i,
  input  logic [MaxCodeWidth-1:0]             code_i,
  input  logic [vwcp_pkg::CodeWidthW-1:0]     code_width_i,
  input  logic                                q_full_i,
  output logic                                job_push_o,
  output vwcp_pkg::job_t                      job_o
);

  localparam int AccW = MaxCodeWidth + vwcp_pkg::ByteW - 1;
  localparam int W    = vwcp_pkg::CodeWidthW;

  logic [vwcp_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [vwcp_pkg::ByteW-1:0]  bits_q, bits_d;

  logic                    take;
  logic [W-1:0]            width;
  logic [MaxCodeWidth-1:0] mask;
  logic [vwcp_pkg::ByteW-1:0] head;
  logic [AccW-1:0]         acc;
  logic [AccW+7:0]         accx;
  logic [W-1:0]            total;
  logic                    two;
  logic [vwcp_pkg::CountW-1:0] nt;

  assign take = push_i && !q_full_i;

  always_comb begin
    if (code_width_i < W'(vwcp_pkg::MinCodeWidth)) begin
      width = W'(vwcp_pkg::MinCodeWidth);
    end else if (code_width_i > W'(MaxCodeWidth)) begin
      width = W'(MaxCodeWidth);
    end else begin
      width = code_width_i;
    end
    mask  = ~({MaxCodeWidth{1'b1}} << width);
    head  = bits_q >> (4'd8 - {1'b0, cnt_q});
    acc   = (AccW'(head) << width) | AccW'(code_i & mask);
    total = W'(cnt_q) + width;
    two   = total >= W'(16);
    nt    = two ? vwcp_pkg::CountW'(total - W'(16)) : vwcp_pkg::CountW'(total - W'(8));
    accx  = {acc, 8'h00} >> nt;
  end

  always_comb begin
    cnt_d      = cnt_q;
    bits_d     = bits_q;
    job_push_o = 1'b0;
    job_o.b0   = 8'(acc >> (total - W'(8)));
    job_o.b1   = 8'(acc >> (total - W'(16)));
    job_o.two  = two;
    if (take) begin
      if (func_i == vwcp_pkg::FuncFlush) begin
        job_o.b0   = bits_q;
        job_o.two  = 1'b0;
        job_push_o = cnt_q != '0;
        cnt_d      = '0;
        bits_d     = '0;
      end else begin
        job_push_o = 1'b1;
        cnt_d      = nt;
        bits_d     = accx[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bits_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      bits_q <= bits_d;
    end
  end

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bits_q & (8'hFF >> cnt_q)) == 8'h00)
    else $error("pending byte has bits beyond the pending count");

endmodule

// ===== rtl/vwcp_queue.sv =====
// Short job queue between the front and back parts of the code packer.
// Register array with head and tail pointers; depends on vwcp_pkg.
module vwcp_queue #(
  parameter int Depth = vwcp_pkg::DefQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  vwcp_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output vwcp_pkg::job_t rd_job_o,
  output logic           full_o,
  output logic           nonempty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vwcp_pkg::job_t  mem [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == CntW'(Depth);
  assign nonempty_o = cnt_q != '0;
  assign rd_job_o   = mem[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr_i) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (rd_i) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wp_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> nonempty_o)
    else $error("job queue read while empty");

endmodule

// ===== rtl/vwcp_back.sv =====
// Back part of the code packer: emits the bytes of each job, one per cycle while pop is held.
// Output register decouples the result side; depends on vwcp_pkg.
module vwcp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_nonempty_i,
  input  vwcp_pkg::job_t             q_job_i,
  output logic                       q_rd_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [vwcp_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_o
);

  logic                       valid_q, valid_d;
  logic                       phase_q, phase_d;
  logic [vwcp_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       last_q, last_d;
  logic                       load;

  assign load = q_nonempty_i && (!valid_q || pop_i);

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    byte_d  = byte_q;
    last_d  = last_q;
    q_rd_o  = 1'b0;
    if (pop_i && valid_q) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      if (q_job_i.two && !phase_q) begin
        byte_d  = q_job_i.b0;
        last_d  = 1'b0;
        phase_d = 1'b1;
      end else begin
        byte_d  = phase_q ? q_job_i.b1 : q_job_i.b0;
        last_d  = 1'b1;
        phase_d = 1'b0;
        q_rd_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

  a_phase_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (valid_q && !last_q))
    else $error("second byte pending without a first byte on the output");

endmodule

// ===== rtl/variable_width_code_packer_top.sv =====
// Variable width code packer: packs 9 to MaxCodeWidth (default 16) bit codes MSB first into bytes.
// A taken request's bytes pass through the job queue and the output register.
// Throughput: one request per cycle while the job queue has room; one byte
// per cycle out while pop is held, so two-byte codes are paced by the output.
// Reset (rst_ni, async, active low) clears pending bits, queue and output.
// Depends on vwcp_pkg, vwcp_front, vwcp_queue, vwcp_back.
module variable_width_code_packer_top #(
  parameter int MaxCodeWidth = vwcp_pkg::DefMaxCodeWidth,
  parameter int QueueDepth   = vwcp_pkg::DefQueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            func_i,
  input  logic [MaxCodeWidth-1:0]         code_i,
  input  logic [vwcp_pkg::CodeWidthW-1:0] code_width_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [vwcp_pkg::ByteW-1:0]      out_byte_o,
  output logic                            last_o
);

  vwcp_pkg::job_t job_in, job_out;
  logic           job_push, q_full, q_nonempty, q_rd;

  assign full = q_full;

  vwcp_front #(
    .MaxCodeWidth(MaxCodeWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .func_i      (func_i),
    .code_i      (code_i),
    .code_width_i(code_width_i),
    .q_full_i    (q_full),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  vwcp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_push),
    .wr_job_i  (job_in),
    .rd_i      (q_rd),
    .rd_job_o  (job_out),
    .full_o    (q_full),
    .nonempty_o(q_nonempty)
  );

  vwcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_nonempty_i(q_nonempty),
    .q_job_i     (job_out),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
